// ===== rtl/quoted_string_escape_decoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quoted string escape decoder
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUOTED_STRING_ESCAPE_DECODER_TOP_ASSERT_SVH
`define QUOTED_STRING_ESCAPE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define QSED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QSED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qsed_pkg.sv =====
// ----------------------------------------------------------------------------
// Quoted string escape decoder package
// Shared result and bundle types, queue status and sizing constants.
// ----------------------------------------------------------------------------
package qsed_pkg;

  // One result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_end;
    logic       closed_by_quote;
  } result_t;

  localparam int RES_SLOTS = 3;
  localparam logic [1:0] RES_MAX = 2'd3;

  // All results caused by one input word, slot 0 first.
  typedef struct packed {
    logic [1:0]                  cnt;
    result_t [RES_SLOTS-1:0]     res;
  } bundle_t;

  // Queue status seen by front and back.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  localparam int QUEUE_DEPTH_DEF = 4;

  // Fixed byte values.
  localparam logic [7:0]  CH_NUL    = 8'h00;
  localparam logic [7:0]  CH_QUOTE  = 8'h22;
  localparam logic [7:0]  CH_BSLASH = 8'h5C;
  localparam logic [7:0]  CH_X      = 8'h78;
  localparam logic [7:0]  ESC_CHAR  = 8'h1B;
  localparam logic [15:0] CRLF      = 16'h0A0D;

endpackage

// ===== rtl/qsed_ifs.sv =====
// ----------------------------------------------------------------------------
// Quoted string escape decoder channels
// Valid/ready channels for source words, result words and configuration.
// ----------------------------------------------------------------------------
interface qsed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       last_in_input;

  modport source (output valid, output src_byte, output last_in_input, input ready);
  modport sink   (input valid, input src_byte, input last_in_input, output ready);
endinterface

interface qsed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       string_end;
  logic       closed_by_quote;

  modport source (output valid, output out_byte, output has_byte, output string_end,
                  output closed_by_quote, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input string_end,
                  input closed_by_quote, output ready);
endinterface

interface qsed_cfg_if;
  logic valid;
  logic ready;
  logic keep_escapes;

  modport source (output valid, output keep_escapes, input ready);
  modport sink   (input valid, input keep_escapes, output ready);
endinterface

// ===== rtl/qsed_front.sv =====
// ----------------------------------------------------------------------------
// Quoted string escape decoder front end
// Accepts source words, runs the escape state machine and builds one bundle
// of up to three results per word.
// ----------------------------------------------------------------------------
module qsed_front (
  input  logic              clk,
  input  logic              rst,
  qsed_in_if.sink           src,
  qsed_cfg_if.sink          cfg,
  input  qsed_pkg::q_stat_t q_stat,
  output logic              push,
  output qsed_pkg::bundle_t push_bundle
);
  import qsed_pkg::*;

  typedef enum logic [5:0] {
    PH_AWAIT = 6'b000001,
    PH_BODY  = 6'b000010,
    PH_ESC   = 6'b000100,
    PH_HEX1  = 6'b001000,
    PH_HEX2  = 6'b010000,
    PH_KEEP  = 6'b100000
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held_digit;
  logic [7:0] held_digit_next;
  logic       keep_escapes;
  logic       accept;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    return v[3:0];
  endfunction

  // {known, decoded byte}; m returns its first byte only
  function automatic logic [8:0] esc_lookup(logic [7:0] c);
    logic [8:0] r;
    r = 9'h000;
    unique case (c)
      8'h61:     r = {1'b1, 8'h07};       // a
      8'h62:     r = {1'b1, 8'h08};       // b
      8'h65:     r = {1'b1, ESC_CHAR};    // e
      8'h66:     r = {1'b1, 8'h0C};       // f
      8'h6C:     r = {1'b1, 8'h0A};       // l
      8'h6D:     r = {1'b1, CRLF[7:0]};   // m
      8'h6E:     r = {1'b1, 8'h0A};       // n
      8'h71:     r = {1'b1, 8'h22};       // q
      8'h72:     r = {1'b1, 8'h0D};       // r
      8'h73:     r = {1'b1, 8'h27};       // s
      8'h5F:     r = {1'b1, 8'h20};       // underscore
      8'h74:     r = {1'b1, 8'h09};       // t
      8'h76:     r = {1'b1, 8'h0B};       // v
      8'h7A:     r = {1'b1, 8'h00};       // z
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_QUOTE:  r = {1'b1, CH_QUOTE};
      default:   r = 9'h000;
    endcase
    return r;
  endfunction

  function automatic bundle_t put_res(bundle_t b, logic [7:0] d, logic has, logic fin,
                                     logic quote);
    bundle_t r;
    r = b;
    if (b.cnt != RES_MAX) begin
      r.res[b.cnt] = '{out_byte: (has ? d : 8'h00), has_byte: has, string_end: fin,
                       closed_by_quote: quote};
      r.cnt = b.cnt + 2'd1;
    end
    return r;
  endfunction

  assign src.ready = !q_stat.full;
  assign cfg.ready = 1'b1;
  assign accept    = src.valid && src.ready;

  always_comb begin
    logic [7:0] b;
    logic       do_body;
    logic       end_now;
    logic       end_quote;
    logic [8:0] esc;
    logic [1:0] lst;
    bundle_t    bnd;

    b               = src.src_byte;
    do_body         = 1'b0;
    end_now         = 1'b0;
    end_quote       = 1'b0;
    esc             = esc_lookup(b);
    lst             = 2'd0;
    bnd             = '0;
    phase_next      = phase;
    held_digit_next = held_digit;

    unique case (phase)
      PH_AWAIT: phase_next = PH_BODY;
      PH_BODY:  do_body = 1'b1;
      PH_ESC: begin
        phase_next = PH_BODY;
        if (b == CH_NUL) begin
          bnd     = put_res(bnd, CH_NUL, 1'b1, 1'b0, 1'b0);
          end_now = 1'b1;
        end else if (b == CH_X) begin
          phase_next = PH_HEX1;
        end else if (esc[8]) begin
          bnd = put_res(bnd, esc[7:0], 1'b1, 1'b0, 1'b0);
          if (b == 8'h6D) bnd = put_res(bnd, CRLF[15:8], 1'b1, 1'b0, 1'b0);
        end else begin
          bnd = put_res(bnd, CH_BSLASH, 1'b1, 1'b0, 1'b0);
          bnd = put_res(bnd, b, 1'b1, 1'b0, 1'b0);
        end
      end
      PH_HEX1: begin
        if (is_hex(b)) begin
          held_digit_next = b;
          phase_next      = PH_HEX2;
        end else begin
          bnd        = put_res(bnd, CH_X, 1'b1, 1'b0, 1'b0);
          phase_next = PH_BODY;
          do_body    = 1'b1;
        end
      end
      PH_HEX2: begin
        phase_next      = PH_BODY;
        held_digit_next = 8'h00;
        if (is_hex(b)) begin
          bnd = put_res(bnd, {hex_val(held_digit), hex_val(b)}, 1'b1, 1'b0, 1'b0);
        end else begin
          bnd     = put_res(bnd, {hex_val(held_digit), 4'h0}, 1'b1, 1'b0, 1'b0);
          bnd     = put_res(bnd, held_digit, 1'b1, 1'b0, 1'b0);
          do_body = 1'b1;
        end
      end
      PH_KEEP: begin
        bnd        = put_res(bnd, b, 1'b1, 1'b0, 1'b0);
        phase_next = PH_BODY;
      end
      default: phase_next = PH_AWAIT;
    endcase

    // ordinary string byte
    if (do_body) begin
      if (b == CH_QUOTE) begin
        end_now   = 1'b1;
        end_quote = 1'b1;
      end else if (b == CH_NUL) begin
        end_now = 1'b1;
      end else if (b == CH_BSLASH) begin
        if (keep_escapes) begin
          bnd        = put_res(bnd, b, 1'b1, 1'b0, 1'b0);
          phase_next = PH_KEEP;
        end else begin
          phase_next = PH_ESC;
        end
      end else begin
        bnd = put_res(bnd, b, 1'b1, 1'b0, 1'b0);
      end
    end

    if (end_now) begin
      bnd             = put_res(bnd, 8'h00, 1'b0, 1'b1, end_quote);
      phase_next      = PH_AWAIT;
      held_digit_next = 8'h00;
    end else if (src.last_in_input) begin
      // flush a pending escape, then mark the end
      if (phase_next == PH_ESC) begin
        bnd = put_res(bnd, CH_BSLASH, 1'b1, 1'b0, 1'b0);
      end else if (phase_next == PH_HEX1) begin
        bnd = put_res(bnd, CH_X, 1'b1, 1'b0, 1'b0);
      end else if (phase_next == PH_HEX2) begin
        bnd = put_res(bnd, {hex_val(held_digit_next), 4'h0}, 1'b1, 1'b0, 1'b0);
        bnd = put_res(bnd, held_digit_next, 1'b1, 1'b0, 1'b0);
      end
      if (bnd.cnt != 2'd0) begin
        lst                       = bnd.cnt - 2'd1;
        bnd.res[lst].string_end   = 1'b1;
      end else begin
        bnd = put_res(bnd, 8'h00, 1'b0, 1'b1, 1'b0);
      end
      phase_next      = PH_AWAIT;
      held_digit_next = 8'h00;
    end

    push_bundle = bnd;
    push        = accept && (bnd.cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_AWAIT;
      held_digit   <= 8'h00;
      keep_escapes <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        held_digit <= held_digit_next;
      end
      if (cfg.valid && cfg.ready) keep_escapes <= cfg.keep_escapes;
    end
  end

endmodule

// ===== rtl/qsed_queue.sv =====
// ----------------------------------------------------------------------------
// Quoted string escape decoder bundle queue
// Small FIFO of result bundles between front end and back end.
// ----------------------------------------------------------------------------
module qsed_queue #(
  parameter int DEPTH = qsed_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  qsed_pkg::bundle_t push_bundle,
  input  logic              pop,
  output qsed_pkg::bundle_t head,
  output qsed_pkg::q_stat_t q_stat
);
  import qsed_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bundle_t          slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == CNT_FULL);
  assign head         = slots[rd_ptr];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/qsed_back.sv =====
// ----------------------------------------------------------------------------
// Quoted string escape decoder back end
// Unpacks bundles into the output register, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module qsed_back (
  input  logic              clk,
  input  logic              rst,
  input  qsed_pkg::bundle_t head,
  input  qsed_pkg::q_stat_t q_stat,
  output logic              pop,
  qsed_out_if.source        res
);
  import qsed_pkg::*;

  bundle_t    cur;
  logic [1:0] idx;
  logic [1:0] left;
  logic       adv;
  result_t    cur_res;
  result_t    head_res;

  assign adv      = !res.valid || res.ready;
  assign cur_res  = cur.res[idx];
  assign head_res = head.res[0];
  assign pop      = adv && (left == 2'd0) && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      left      <= 2'd0;
      idx       <= 2'd0;
    end else if (adv) begin
      if (left != 2'd0) begin
        res.valid <= 1'b1;
        idx       <= idx + 2'd1;
        left      <= left - 2'd1;
      end else if (!q_stat.empty) begin
        res.valid <= 1'b1;
        idx       <= 2'd1;
        left      <= head.cnt - 2'd1;
      end else begin
        res.valid <= 1'b0;
      end
    end
  end

  // payload path, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      if (left != 2'd0) begin
        res.out_byte        <= cur_res.out_byte;
        res.has_byte        <= cur_res.has_byte;
        res.string_end      <= cur_res.string_end;
        res.closed_by_quote <= cur_res.closed_by_quote;
      end else if (!q_stat.empty) begin
        res.out_byte        <= head_res.out_byte;
        res.has_byte        <= head_res.has_byte;
        res.string_end      <= head_res.string_end;
        res.closed_by_quote <= head_res.closed_by_quote;
        cur                 <= head;
      end
    end
  end

endmodule

// ===== rtl/quoted_string_escape_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Quoted string escape decoder
// Decodes a quoted, backslash-escaped byte string into its string bytes.
// ----------------------------------------------------------------------------
// Channels:
//   src - source words: src_byte plus last_in_input. The first word of each
//         string is the opening quote and is dropped unchecked.
//   res - result words: out_byte, has_byte, string_end, closed_by_quote.
//         Each source word yields zero to three result words.
//   cfg - keep_escapes write; write only while the block is idle.
// Path: the front end writes each accepted word's bundle into the queue, and
//   the back end then loads its result words from the queue into the output
//   register.
// Throughput: one source word per cycle while no word yields more than one
//   result and res is not held off; the back end drains one result word per
//   cycle unless stalled, and the queue absorbs bursts of multi-result words.
// Stall: when res is held off the output register holds its word, the queue
//   fills, and src.ready drops once all QUEUE_DEPTH slots are taken.
// Reset: state returns to waiting for an opening quote, keep_escapes to 0,
//   queue and output register empty.
// ----------------------------------------------------------------------------
module quoted_string_escape_decoder_top #(
  parameter int QUEUE_DEPTH = qsed_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  qsed_in_if.sink    src,
  qsed_out_if.source res,
  qsed_cfg_if.sink   cfg
);
  import qsed_pkg::*;

  logic    push;
  logic    pop;
  bundle_t push_bundle;
  bundle_t head;
  q_stat_t q_stat;

  // escape state machine, at most one bundle per accepted word
  qsed_front u_front (
    .clk         (clk),
    .rst         (rst),
    .src         (src),
    .cfg         (cfg),
    .q_stat      (q_stat),
    .push        (push),
    .push_bundle (push_bundle)
  );

  // decouples the front end from output backpressure
  qsed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (push_bundle),
    .pop         (pop),
    .head        (head),
    .q_stat      (q_stat)
  );

  // serializes bundles into result words
  qsed_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .res    (res)
  );

endmodule

// ===== rtl/qsed_checker.sv =====
// ----------------------------------------------------------------------------
// Quoted string escape decoder checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "quoted_string_escape_decoder_top_assert.svh"

module qsed_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] out_byte,
  input logic       has_byte,
  input logic       string_end,
  input logic       closed_by_quote
);

  `QSED_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(out_byte) && $stable(has_byte) && $stable(string_end) && $stable(closed_by_quote), "result word changed while stalled")
  `QSED_ASSERT_NOW(a_empty_zero, res_valid && !has_byte, out_byte == 8'h00, "out_byte nonzero without a byte")
  `QSED_ASSERT_NOW(a_empty_is_end, res_valid && !has_byte, string_end, "byteless result that is not an end")
  `QSED_ASSERT_NOW(a_quote_is_end, res_valid && closed_by_quote, string_end && !has_byte, "quote flag off the end result")

endmodule

bind quoted_string_escape_decoder_top qsed_checker u_qsed_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .out_byte        (res.out_byte),
  .has_byte        (res.has_byte),
  .string_end      (res.string_end),
  .closed_by_quote (res.closed_by_quote)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted string escape decoder testbench
// Feeds quoted, backslash-escaped byte strings with random bursts and gaps,
// stalls the result channel on its own pattern, and checks every result word
// against a decoder model kept in step with the accepted source words.
// ----------------------------------------------------------------------------
module tb_top;
  import qsed_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no word moving on any channel
  localparam int SETTLE_CYCLES  = 8;     // queue and output register, plus margin
  localparam int TAIL_CYCLES    = 16;
  localparam int PHASE_WORDS    = 32;    // random source words per config phase
  localparam int REPORT_MAX     = 10;

  // Decoder scan position, mirrors the block's escape handling.
  typedef enum logic [2:0] {
    SC_AWAIT,  // next word is the opening quote
    SC_BODY,
    SC_ESC,    // backslash seen, decode mode
    SC_HEX1,   // \x seen, no digit yet
    SC_HEX2,   // \x and one digit seen
    SC_KEEP    // backslash seen, keep mode: next word copied raw
  } scan_t;

  typedef enum logic [1:0] {FIN_NONE, FIN_QUOTE, FIN_NUL} fin_t;

  // Result channel stall styles.
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } src_word_t;

  // Known escape letters; everything else but x and NUL takes the unknown-escape path.
  localparam logic [7:0] ESC_KEYS [0:15] = '{"a", "b", "e", "f", "l", "n", "q", "r",
                                              "s", "_", "t", "v", "z", CH_BSLASH,
                                              CH_QUOTE, "m"};

  logic clk = 1'b0;
  logic rst = 1'b1;

  qsed_in_if  src_ch ();
  qsed_out_if res_ch ();
  qsed_cfg_if cfg_ch ();

  quoted_string_escape_decoder_top i_dut (
    .clk (clk),
    .rst (rst),
    .src (src_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state: scan position, first hex digit of a \x, keep mode copy.
  scan_t      scan      = SC_AWAIT;
  logic [7:0] hex_first = 8'h00;
  logic       keep_mode = 1'b0;

  result_t    step_q[$];        // results of the word being decoded
  result_t    due_results[$];   // decoded words not yet seen on res
  src_word_t  word_backlog[$];  // source words waiting for the driver

  int mismatches  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int rx_left     = 0;
  int rx_tick     = 0;
  rx_mode_t rx_mode = RX_OPEN;

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------
  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return 10 + int'(c) - int'("a");
    if (c >= "A" && c <= "F") return 10 + int'(c) - int'("A");
    return -1;
  endfunction

  // At most RES_SLOTS results per word; extras are dropped like the block does.
  task automatic emit(input logic [7:0] b, input logic has, input logic fin,
                      input logic closed);
    result_t r;
    r.out_byte        = has ? b : 8'h00;
    r.has_byte        = has;
    r.string_end      = fin;
    r.closed_by_quote = closed;
    if (step_q.size() < RES_SLOTS) step_q.push_back(r);
  endtask

  task automatic put_byte(input logic [7:0] b);
    emit(b, 1'b1, 1'b0, 1'b0);
  endtask

  // Plain body byte: quote and NUL end the string, backslash opens an escape.
  task automatic body_char(input logic [7:0] b, output fin_t fin);
    fin = FIN_NONE;
    if (b == CH_QUOTE) begin
      fin = FIN_QUOTE;
    end else if (b == CH_NUL) begin
      fin = FIN_NUL;
    end else if (b == CH_BSLASH) begin
      if (keep_mode) begin
        put_byte(b);
        scan = SC_KEEP;
      end else begin
        scan = SC_ESC;
      end
    end else begin
      put_byte(b);
    end
  endtask

  task automatic decode_word(input logic [7:0] b, input logic lst);
    fin_t fin;
    int   hi;
    int   lo;
    fin = FIN_NONE;
    step_q.delete();
    hi = hex_val(hex_first);
    lo = hex_val(b);
    case (scan)
      SC_AWAIT: scan = SC_BODY;   // opening quote, not checked
      SC_BODY:  body_char(b, fin);
      SC_ESC: begin
        scan = SC_BODY;
        case (b)
          CH_NUL: begin
            put_byte(CH_NUL);
            fin = FIN_NUL;
          end
          "a":       put_byte(8'h07);
          "b":       put_byte(8'h08);
          "e":       put_byte(ESC_CHAR);
          "f":       put_byte(8'h0C);
          "l":       put_byte(8'h0A);
          "m": begin
            put_byte(CRLF[7:0]);
            put_byte(CRLF[15:8]);
          end
          "n":       put_byte(8'h0A);
          "q":       put_byte(CH_QUOTE);
          "r":       put_byte(8'h0D);
          "s":       put_byte(8'h27);
          "_":       put_byte(8'h20);
          "t":       put_byte(8'h09);
          "v":       put_byte(8'h0B);
          "z":       put_byte(8'h00);
          CH_BSLASH: put_byte(CH_BSLASH);
          CH_QUOTE:  put_byte(CH_QUOTE);
          CH_X:      scan = SC_HEX1;
          default: begin
            put_byte(CH_BSLASH);
            put_byte(b);
          end
        endcase
      end
      SC_HEX1: begin
        if (lo >= 0) begin
          hex_first = b;
          scan      = SC_HEX2;
        end else begin
          // \x with no digit: literal x, then the byte is plain body
          put_byte(CH_X);
          scan = SC_BODY;
          body_char(b, fin);
        end
      end
      SC_HEX2: begin
        scan = SC_BODY;
        if (lo >= 0) begin
          put_byte({hi[3:0], lo[3:0]});
        end else begin
          // one digit only: digit<<4, the digit char, then a plain byte
          put_byte({hi[3:0], 4'h0});
          put_byte(hex_first);
          body_char(b, fin);
        end
        hex_first = 8'h00;
      end
      SC_KEEP: begin
        put_byte(b);
        scan = SC_BODY;
      end
      default: scan = SC_AWAIT;
    endcase

    if (fin != FIN_NONE) begin
      emit(8'h00, 1'b0, 1'b1, fin == FIN_QUOTE);
      scan      = SC_AWAIT;
      hex_first = 8'h00;
    end else if (lst) begin
      // flush a half-done escape, then mark the end
      case (scan)
        SC_ESC:  put_byte(CH_BSLASH);
        SC_HEX1: put_byte(CH_X);
        SC_HEX2: begin
          hi = hex_val(hex_first);
          put_byte({hi[3:0], 4'h0});
          put_byte(hex_first);
        end
        default: ;
      endcase
      if (step_q.size() > 0) step_q[step_q.size() - 1].string_end = 1'b1;
      else emit(8'h00, 1'b0, 1'b1, 1'b0);
      scan      = SC_AWAIT;
      hex_first = 8'h00;
    end

    foreach (step_q[i]) due_results.push_back(step_q[i]);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_word(input logic [7:0] b, input logic lst);
    src_word_t w;
    w.b    = b;
    w.last = lst;
    word_backlog.push_back(w);
  endtask

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'("0" + v);
    if (v < 16) return 8'("a" + v - 10);
    return 8'("A" + v - 16);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (hex_val(b) >= 0);
    return b;
  endfunction

  // Any byte that stays in the body: not NUL, quote or backslash.
  function automatic logic [7:0] plain_byte(input bit printable);
    logic [7:0] b;
    do begin
      b = printable ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom_range(1, 255));
    end while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  // One random string: mostly well formed with random escapes, a few noise runs.
  task automatic gen_string(output int added);
    src_word_t s[$];
    src_word_t w;
    int        body_len;
    int        term;
    logic [7:0] seq[$];

    if ($urandom_range(0, 9) == 0) begin
      // noise: raw bytes with a scattered last flag
      repeat ($urandom_range(3, 8)) begin
        w.b    = 8'($urandom_range(0, 255));
        w.last = ($urandom_range(0, 7) == 0);
        s.push_back(w);
      end
    end else begin
      seq.push_back(8'($urandom_range(0, 255)));  // opening quote, any value
      body_len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 7);
      repeat (body_len) begin
        case ($urandom_range(0, 15))
          7, 8: begin
            seq.push_back(CH_BSLASH);
            seq.push_back(ESC_KEYS[$urandom_range(0, 15)]);
          end
          9: begin
            seq.push_back(CH_BSLASH);
            seq.push_back(8'($urandom_range(0, 255)));
          end
          10: begin
            seq.push_back(CH_BSLASH);
            seq.push_back(CH_X);
            seq.push_back(hex_char());
            seq.push_back(hex_char());
          end
          11: begin
            seq.push_back(CH_BSLASH);
            seq.push_back(CH_X);
            seq.push_back(hex_char());
            seq.push_back(non_hex());
          end
          12: begin
            seq.push_back(CH_BSLASH);
            seq.push_back(CH_X);
            seq.push_back(non_hex());
          end
          13: begin
            seq.push_back(CH_BSLASH);
            seq.push_back("m");
          end
          14, 15:  seq.push_back(plain_byte(1'b1));
          default: seq.push_back(plain_byte(1'b0));
        endcase
      end
      foreach (seq[i]) begin
        w.b    = seq[i];
        w.last = 1'b0;
        s.push_back(w);
      end
      term = $urandom_range(0, 19);
      if (term <= 7) begin
        w.b    = CH_QUOTE;
        w.last = ($urandom_range(0, 3) == 0);
        s.push_back(w);
      end else if (term <= 9) begin
        w.b    = CH_NUL;
        w.last = 1'b0;
        s.push_back(w);
      end else if (term <= 14) begin
        s[s.size() - 1].last = 1'b1;
      end else if (term <= 18) begin
        // input runs out inside an escape
        w.last = 1'b0;
        w.b    = CH_BSLASH;
        s.push_back(w);
        if (term >= 17) begin
          w.b = CH_X;
          s.push_back(w);
        end
        if (term == 18) begin
          w.b = hex_char();
          s.push_back(w);
        end
        s[s.size() - 1].last = 1'b1;
      end
      // term 19: no end, the next string runs on from here
    end
    foreach (s[i]) word_backlog.push_back(s[i]);
    added = s.size();
  endtask

  // Wait until every word is in and every result is out, then let the pipe drain.
  task automatic settle();
    do @(negedge clk);
    while (word_backlog.size() != 0 || src_ch.valid || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep(input logic v);
    @(posedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.keep_escapes <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    keep_mode = v;
    cfg_ch.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Source driver: bursts of random length with random gaps, some gap-free.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_src
    src_word_t w;
    if (rst) begin
      src_ch.valid         <= 1'b0;
      src_ch.src_byte      <= 8'h00;
      src_ch.last_in_input <= 1'b0;
    end else if (!src_ch.valid || src_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        src_ch.valid <= 1'b0;
      end else if (word_backlog.size() > 0) begin
        w = word_backlog.pop_front();
        src_ch.valid         <= 1'b1;
        src_ch.src_byte      <= w.b;
        src_ch.last_in_input <= w.last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        src_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result ready: switches between randomly chosen stall styles.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_ready
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 96);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:  res_ch.ready <= 1'b1;
        RX_LIGHT: res_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default:  res_ch.ready <= rx_tick[2];  // bursty: follows bit 2 of rx_tick
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Model update on accepted source words, check on accepted result words.
  // Model runs first so a same-edge result still finds its expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (!rst) begin
      if (src_ch.valid && src_ch.ready) decode_word(src_ch.src_byte, src_ch.last_in_input);
      if (res_ch.valid && res_ch.ready) begin
        got.out_byte        = res_ch.out_byte;
        got.has_byte        = res_ch.has_byte;
        got.string_end      = res_ch.string_end;
        got.closed_by_quote = res_ch.closed_by_quote;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected result word: byte %h has %b end %b quote %b",
                     $realtime, got.out_byte, got.has_byte, got.string_end,
                     got.closed_by_quote);
        end else begin
          want = due_results.pop_front();
          if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
              got.string_end !== want.string_end ||
              got.closed_by_quote !== want.closed_by_quote) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: result mismatch: exp byte %h has %b end %b quote %b, got byte %h has %b end %b quote %b",
                       $realtime, want.out_byte, want.has_byte, want.string_end,
                       want.closed_by_quote, got.out_byte, got.has_byte,
                       got.string_end, got.closed_by_quote);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with nothing moving on any channel ends the run.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if (rst) begin
      idle_cycles = 0;
    end else if ((src_ch.valid && src_ch.ready) || (res_ch.valid && res_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no traffic for %0d cycles", $realtime, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic phase_keep [0:5];
    int   n;
    int   added;

    src_ch.valid         = 1'b0;
    src_ch.src_byte      = 8'h00;
    src_ch.last_in_input = 1'b0;
    res_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.keep_escapes  = 1'b0;
    phase_keep = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed, decode mode (reset value of keep_escapes).
    add_word(8'hFF, 1'b0);                          // opening, not checked
    add_word(8'h01, 1'b0);                          // lowest plain byte
    add_word(8'hFF, 1'b0);                          // highest plain byte
    add_word(CH_BSLASH, 1'b0); add_word("m", 1'b0); // CR LF pair
    add_word(CH_BSLASH, 1'b0); add_word(CH_X, 1'b0);
    add_word("4", 1'b0);       add_word("g", 1'b0); // single hex digit, then plain g
    add_word(CH_BSLASH, 1'b0); add_word(CH_X, 1'b0);
    add_word("a", 1'b0);       add_word("F", 1'b0); // two digits, mixed case
    add_word(CH_BSLASH, 1'b0); add_word("k", 1'b0); // unknown escape
    add_word(CH_BSLASH, 1'b0); add_word(CH_NUL, 1'b0); // backslash NUL: emit 00, end
    add_word(CH_NUL, 1'b0);                         // opening
    add_word(CH_BSLASH, 1'b0); add_word(CH_X, 1'b1); // input ends after \x
    add_word(CH_QUOTE, 1'b0); add_word(CH_QUOTE, 1'b1); // empty string, quote+last
    settle();

    // Directed, keep mode; leaves a backslash pending across the mode change.
    write_keep(1'b1);
    add_word(CH_QUOTE, 1'b0);
    add_word(CH_BSLASH, 1'b0); add_word(CH_QUOTE, 1'b0); // raw copy of \"
    add_word(CH_NUL, 1'b0);                         // NUL end
    add_word(CH_QUOTE, 1'b0); add_word(CH_BSLASH, 1'b0);
    settle();

    // Random phases, each in the mode given by phase_keep.
    foreach (phase_keep[p]) begin
      write_keep(phase_keep[p]);
      n = 0;
      while (n < PHASE_WORDS) begin
        gen_string(added);
        n += added;
      end
      // sometimes stop inside an escape so the next mode meets it
      if ($urandom_range(0, 1) == 0) begin
        add_word(CH_QUOTE, 1'b0);
        add_word(CH_BSLASH, 1'b0);
      end
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/qsed_pkg.sv
rtl/qsed_ifs.sv
rtl/qsed_front.sv
rtl/qsed_queue.sv
rtl/qsed_back.sv
rtl/quoted_string_escape_decoder_top.sv
rtl/qsed_checker.sv
sim/tb_top.sv
